// ===== design/ppmenc_pkg.sv =====
// Package for the PPM P3 pixel text encoder.
// Holds the ASCII codes, sizing constants and the decimal digit split.
// No dependencies.
`timescale 1ns / 1ps

package ppmenc_pkg;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;

	localparam int unsigned MAX_LEVEL = 255;
	localparam int unsigned MAX_BYTES = 13;
	localparam int unsigned LINE_W    = 7;
	localparam int unsigned COUNT_W   = 4;

	typedef logic [LINE_W-1:0]  line_len_t;
	typedef logic [COUNT_W-1:0] byte_count_t;

	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
		logic [1:0] len;
	} digits_t;

	// Splits 0..255 into decimal digits. The tens digit uses a reciprocal
	// multiply by 205 / 2048, exact for remainders below 100.
	function automatic digits_t to_decimal(input logic [7:0] value);
		digits_t    d;
		logic [7:0] rem;
		logic [14:0] recip;
		logic [6:0] rem7;
		if (value >= 8'd200) begin
			d.hundreds = 4'd2;
			rem        = value - 8'd200;
		end else if (value >= 8'd100) begin
			d.hundreds = 4'd1;
			rem        = value - 8'd100;
		end else begin
			d.hundreds = 4'd0;
			rem        = value;
		end
		rem7   = rem[6:0];
		recip  = 15'(rem7) * 15'd205;
		d.tens = recip[14:11];
		d.ones = 4'(rem7 - 7'(d.tens) * 7'd10);
		if (value >= 8'd100) begin
			d.len = 2'd3;
		end else if (value >= 8'd10) begin
			d.len = 2'd2;
		end else begin
			d.len = 2'd1;
		end
		return d;
	endfunction

endpackage

// ===== design/ppm_p3_pixel_text_encoder.sv =====
// Top level of the PPM P3 pixel text encoder.
// Depends on ppmenc_pkg for ASCII codes, sizes and the decimal split.
// Contains the input register, the pixel encoder and the byte serializer.
`timescale 1ns / 1ps

// Usage
// The input channel takes one pixel per beat (red, green, blue as signed
// fixed point with FRACTION_BITS fraction bits, plus last_in_row) under
// in_valid / in_ready. The output channel gives one ASCII byte per beat
// (text_byte) under out_valid / out_ready, with last_byte high on the final
// byte that a pixel produces.
// A pixel accepted into the input register is encoded there and loaded into
// the byte buffer once the buffer is empty or gives up its last byte; its
// first byte is then offered from the byte buffer.
// Each pixel yields 5 to 13 bytes, and the output port moves one byte per
// cycle while out_ready is high. The input register takes the next pixel
// while the buffer still drains, and the buffer reloads in the same cycle
// that its last byte is taken, so the output runs without gaps.
// When the receiver stalls, the buffer holds its byte and the input register
// holds one waiting pixel, after which in_ready drops.
// Reset clears both valid flags and the running line length; no pass over
// any storage follows reset.
module ppm_p3_pixel_text_encoder #(
	parameter int LINE_LIMIT    = 70,
	parameter int FRACTION_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] red,
	input  logic signed [15:0] green,
	input  logic signed [15:0] blue,
	input  logic               last_in_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         text_byte,
	output logic               last_byte
);

	import ppmenc_pkg::*;

	localparam int unsigned BUF_W = MAX_BYTES * 8;
	localparam logic signed [24:0] ROUND_HALF = 25'(1) <<< (FRACTION_BITS - 1);
	localparam logic [7:0] LIMIT_8 = 8'(LINE_LIMIT);

	// Scale by 255 with round half up, clamped to 0..255.
	function automatic logic [7:0] scale_channel(input logic signed [15:0] raw);
		logic signed [24:0] wide;
		logic signed [24:0] prod;
		logic signed [24:0] shifted;
		wide    = 25'(raw);
		prod    = (wide <<< 8) - wide + ROUND_HALF;
		shifted = prod >>> FRACTION_BITS;
		if (prod < 0) begin
			return 8'd0;
		end else if (shifted > 25'sd255) begin
			return 8'(MAX_LEVEL);
		end
		return shifted[7:0];
	endfunction

	// Input register.
	logic               valid_s1;
	logic signed [15:0] red_s1;
	logic signed [15:0] green_s1;
	logic signed [15:0] blue_s1;
	logic               last_s1;

	// Byte buffer, byte 0 is the final byte of the pixel.
	logic        valid_s2;
	byte_count_t rem_s2;
	logic [7:0]  bytes_s2 [MAX_BYTES];

	line_len_t line_length_q;

	logic load_s2;
	logic out_fire;
	logic [BUF_W-1:0] enc_bytes;
	byte_count_t      enc_count;
	line_len_t        enc_line_length;
	byte_count_t      rd_idx;

	assign out_fire = valid_s2 && out_ready;
	assign load_s2  = valid_s1 && (!valid_s2 || (out_fire && rem_s2 == byte_count_t'(1)));
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			last_s1  <= last_in_row;
		end
	end

	// Encoder: three numbers with their separators, then the row-end
	// newline. Bytes pack in from the low end, so earlier bytes move up.
	always_comb begin
		logic [7:0]  level [3];
		digits_t     d;
		logic [23:0] digit_word;
		logic [31:0] chunk;
		logic [2:0]  n;
		logic [7:0]  sum;
		line_len_t   ll;
		logic [BUF_W-1:0] acc;
		byte_count_t cnt;
		level[0] = scale_channel(red_s1);
		level[1] = scale_channel(green_s1);
		level[2] = scale_channel(blue_s1);
		ll  = line_length_q;
		acc = '0;
		cnt = '0;
		for (int i = 0; i < 3; i++) begin
			d = to_decimal(level[i]);
			case (d.len)
				2'd3: digit_word = {CHAR_ZERO | 8'(d.hundreds), CHAR_ZERO | 8'(d.tens),
				                    CHAR_ZERO | 8'(d.ones)};
				2'd2: digit_word = {8'd0, CHAR_ZERO | 8'(d.tens), CHAR_ZERO | 8'(d.ones)};
				default: digit_word = {16'd0, CHAR_ZERO | 8'(d.ones)};
			endcase
			sum = 8'(ll) + 8'(d.len) + 8'd1;
			if (sum >= LIMIT_8) begin
				chunk = 32'(digit_word) | (32'(CHAR_NEWLINE) << {d.len, 3'b000});
				n     = 3'(d.len) + 3'd1;
				ll    = line_len_t'(d.len);
			end else if (ll != '0) begin
				chunk = 32'(digit_word) | (32'(CHAR_SPACE) << {d.len, 3'b000});
				n     = 3'(d.len) + 3'd1;
				ll    = sum[LINE_W-1:0];
			end else begin
				chunk = 32'(digit_word);
				n     = 3'(d.len);
				ll    = line_len_t'(d.len);
			end
			acc = (acc << {n, 3'b000}) | BUF_W'(chunk);
			cnt = cnt + byte_count_t'(n);
		end
		if (last_s1) begin
			acc = (acc << 8) | BUF_W'(CHAR_NEWLINE);
			cnt = cnt + byte_count_t'(1);
			ll  = '0;
		end
		enc_bytes       = acc;
		enc_count       = cnt;
		enc_line_length = ll;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= '0;
			valid_s2      <= 1'b0;
			rem_s2        <= '0;
		end else if (load_s2) begin
			line_length_q <= enc_line_length;
			valid_s2      <= 1'b1;
			rem_s2        <= enc_count;
		end else if (out_fire) begin
			rem_s2 <= rem_s2 - byte_count_t'(1);
			if (rem_s2 == byte_count_t'(1)) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				bytes_s2[i] <= enc_bytes[8*i +: 8];
			end
		end
	end

	assign rd_idx    = rem_s2 - byte_count_t'(1);
	assign out_valid = valid_s2;
	assign text_byte = bytes_s2[rd_idx];
	assign last_byte = (rem_s2 == byte_count_t'(1));

	// A taken byte that is not the last leaves the buffer still valid.
	a_no_early_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && rem_s2 > byte_count_t'(1)) |=> valid_s2)
		else $error("byte buffer emptied before its last byte");

	// The running line length never reaches the limit.
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		8'(line_length_q) < LIMIT_8)
		else $error("line length reached the line limit");

	// Every pixel loads between 3 and 13 bytes.
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> (rem_s2 >= byte_count_t'(3) && rem_s2 <= byte_count_t'(MAX_BYTES)))
		else $error("pixel byte count out of range");

	// While the buffer is valid it always has bytes left.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rem_s2 != '0)
		else $error("valid buffer with no bytes left");

endmodule

// ===== dv/ppm_p3_pixel_text_encoder_tb.sv =====
// Self-checking testbench for ppm_p3_pixel_text_encoder.
// Holds a scoreboard class that predicts the PPM P3 text stream, plus the tasks that drive it.
// Depends on ppmenc_pkg and the encoder RTL.
`timescale 1ns / 1ps

module ppm_p3_pixel_text_encoder_tb;

	import ppmenc_pkg::*;

	// The DUT runs with its default sizing, and the predictor uses the same values.
	localparam int LINE_CHARS = 70;
	localparam int FRAC_BITS  = 12;

	// One expected output beat: the ASCII character and the end-of-pixel flag.
	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_beat_t;

	// The scoreboard keeps its own copy of the running line length. For each pixel
	// that is accepted it appends the characters that the pixel must produce.
	// Each output beat is then checked against the oldest pending character.
	class ppm_text_scoreboard;
		text_beat_t expected_text[$];
		int         line_len;
		int         errors;

		function new();
			line_len = 0;
			errors   = 0;
		endfunction

		// Scales by 255, rounds half up, and clamps to 0..255.
		function logic [7:0] channel_level(logic signed [15:0] raw);
			longint s;
			s = longint'(raw) * longint'(MAX_LEVEL) + (longint'(1) << (FRAC_BITS - 1));
			if (s < 0)
				return 8'd0;
			s = s >>> FRAC_BITS;
			if (s > longint'(MAX_LEVEL))
				return 8'(MAX_LEVEL);
			return 8'(s);
		endfunction

		function void pixel_accepted(logic signed [15:0] r, logic signed [15:0] g,
				logic signed [15:0] b, logic row_end);
			logic signed [15:0] chan[3];
			logic [7:0]         chars[$];
			logic [7:0]         level;
			int                 ndig;
			text_beat_t         beat;
			chan = '{r, g, b};
			for (int i = 0; i < 3; i++) begin
				level = channel_level(chan[i]);
				ndig  = (level >= 100) ? 3 : (level >= 10) ? 2 : 1;
				// A number that would reach the line limit starts a new line. A number
				// at the start of a line gets no separator at all.
				if (line_len + ndig + 1 >= LINE_CHARS) begin
					chars.push_back(CHAR_NEWLINE);
					line_len = 0;
				end else if (line_len > 0) begin
					chars.push_back(CHAR_SPACE);
					line_len++;
				end
				if (ndig == 3)
					chars.push_back(CHAR_ZERO + 8'(level / 100));
				if (ndig >= 2)
					chars.push_back(CHAR_ZERO + 8'((level / 10) % 10));
				chars.push_back(CHAR_ZERO + 8'(level % 10));
				line_len += ndig;
			end
			if (row_end) begin
				chars.push_back(CHAR_NEWLINE);
				line_len = 0;
			end
			foreach (chars[k]) begin
				beat.text = chars[k];
				beat.last = (k == chars.size() - 1);
				expected_text.push_back(beat);
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_byte(logic [7:0] text, logic last);
			text_beat_t want;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("byte 8'h%02h arrived with nothing pending", text));
			end else begin
				want = expected_text.pop_front();
				if (text !== want.text)
					report_mismatch($sformatf("text_byte 8'h%02h, wanted 8'h%02h",
						text, want.text));
				if (last !== want.last)
					report_mismatch($sformatf("last_byte %b, wanted %b on byte 8'h%02h",
						last, want.last, want.text));
			end
		endtask

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	// Every input of the DUT has a known value from time zero.
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic signed [15:0] red         = '0;
	logic signed [15:0] green       = '0;
	logic signed [15:0] blue        = '0;
	logic               last_in_row = 1'b0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [7:0]         text_byte;
	logic               last_byte;

	// Idle percentages for each side. The stimulus changes them per phase.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	// This is set by the stimulus; the receiver marks the hold-off as served once it is over.
	bit          hold_request = 1'b0;
	bit          hold_served  = 1'b0;

	ppm_text_scoreboard sb;

	ppm_p3_pixel_text_encoder #(
		.LINE_LIMIT   (LINE_CHARS),
		.FRACTION_BITS(FRAC_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_in_row(last_in_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.text_byte  (text_byte),
		.last_byte  (last_byte)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Both channels are sampled at the rising edge, before the DUT and the drivers
	// update anything through their nonblocking assignments. A pixel can never come
	// back out at the edge where it goes in, so the order of the two checks is safe.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.pixel_accepted(red, green, blue, last_in_row);
		if (arst_n && out_valid && out_ready)
			sb.check_byte(text_byte, last_byte);
	end

	// Receiver. Each cycle it decides out_ready from the current idle rate. When a
	// hold-off is requested, it keeps ready low for a long stretch that it counts itself.
	// In that time the byte buffer and the input register fill up, and in_ready
	// must drop while the sender keeps valid high.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_served = 1'b1;
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Returns the raw Q4.12 value that scales to exactly the given 8-bit level.
	// It is level * 2^12 / 255, rounded up.
	function automatic logic signed [15:0] level_to_raw(int level);
		return 16'(((level << FRAC_BITS) + 254) / 255);
	endfunction

	// Random channel. Most values land in 0..255 so that the digit counts vary,
	// and the rest are negative, above full intensity, or any 16-bit pattern.
	function automatic logic signed [15:0] random_channel();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick <= 4)
			return level_to_raw($urandom_range(255));
		else if (pick <= 6)
			return 16'($urandom());
		else if (pick == 7)
			return -16'($urandom_range(32768, 1));
		else if (pick == 8)
			return 16'($urandom_range(32767, 4097));
		else
			return level_to_raw($urandom_range(12));
	endfunction

	// Offers one pixel. Idle gaps only come before valid is raised. Once valid is
	// high it stays high with a fixed payload until the beat is taken. Valid is not
	// lowered after acceptance, so a back-to-back pixel keeps it high with no glitch.
	task automatic send_pixel(logic signed [15:0] r, logic signed [15:0] g,
			logic signed [15:0] b, logic row_end);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		red         <= r;
		green       <= g;
		blue        <= b;
		last_in_row <= row_end;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_levels(int r, int g, int b, logic row_end);
		send_pixel(level_to_raw(r), level_to_raw(g), level_to_raw(b), row_end);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. It runs with mild idling on both sides.
		tx_idle_pct = 10;
		rx_idle_pct = 30;
		// Zero at the start of a line gets no leading separator.
		send_pixel(16'sd0, 16'sd0, 16'sd0, 1'b0);
		// Both extremes of the field, and exact full intensity.
		send_pixel(16'sh7FFF, -16'sh8000, 16'sd4096, 1'b0);
		// Just below full intensity, and just above it.
		send_pixel(16'sd4095, 16'sd4096, 16'sd4097, 1'b0);
		// An exact half that rounds up to 128, a negative half, and minus one.
		send_pixel(16'sd2048, -16'sd2048, -16'sd1, 1'b1);
		// Digit-count boundaries.
		send_levels(9, 10, 99, 1'b0);
		send_levels(100, 254, 255, 1'b1);
		// Long rows of three-digit numbers force a line break in the middle of a row.
		repeat (7) send_levels(255, 200, 199, 1'b0);
		send_levels(0, 0, 0, 1'b1);
		repeat (9) send_levels(1, 255, 100, 1'b0);
		// A single-pixel row, and alternating bit patterns.
		send_levels(1, 1, 1, 1'b1);
		send_pixel(16'sh5555, 16'shAAAA, 16'sh0555, 1'b1);

		// Random part. There are three phases of idling. The long receiver hold-off
		// comes at the start of the last phase, while the sender is pushing at full rate.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct = 57;
				end
				1: begin
					tx_idle_pct = 57;
					rx_idle_pct = 7;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_idle_pct  = 0;
					hold_request = 1'b1;
				end
			endcase
			repeat (150)
				send_pixel(random_channel(), random_channel(), random_channel(),
					$urandom_range(7) == 0);
		end
		in_valid <= 1'b0;

		// Drain. Then allow a short tail so that any stray extra byte is caught.
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Run limit. It is far more than the slowest correct run needs,
	// with about 475 pixels at up to 13 bytes each, the receiver idle 57% of the
	// time, and one long hold-off.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== ppm_p3_pixel_text_encoder.f =====
design/ppmenc_pkg.sv
design/ppm_p3_pixel_text_encoder.sv
dv/ppm_p3_pixel_text_encoder_tb.sv
